// ----- hw/rtl/ocne_pkg.sv -----
// ----------------------------------------------------------------------------
// ocne_pkg
// Shared types, widths and helpers for the ordered cloud normal estimator.
// ----------------------------------------------------------------------------
package ocne_pkg;

  localparam int CRD_W  = 32;             // internal coordinate width
  localparam int MUL_W  = CRD_W + 1;      // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;

  typedef logic signed [CRD_W-1:0]  coord_t;
  typedef logic signed [CRD_W:0]    diff_t;
  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] mul_prod_t;

  // (d / 2) truncated toward zero
  function automatic coord_t half_diff(input diff_t d);
    diff_t t;
    t = d + (d[CRD_W] ? diff_t'(1) : diff_t'(0));
    return coord_t'(t >>> 1);
  endfunction

endpackage

// ----- hw/rtl/ordered_cloud_normal_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_cloud_normal_estimator_unit
// Normal of each interior point of an organized cloud streamed row-major.
//
//  channel | signals                                   | dir
//  in      | in_valid/in_ready, start_cloud, pos, origin| in
//  out     | out_valid/out_ready, row/col, normal, flag | out
//  cfg     | cfg_valid/cfg_ready, cfg_data (row width)  | in
//
// Border points are only stored in the line buffer; interior ones pass through
// accept, line buffer reads, cross product, magnitude, scale shift, squares,
// square root, zero check, three divides of 17 quotient bits, view test, flip
// and output load. A zero cross product skips the divides, view test and flip.
// The result word sits in an output register, so the next word is taken while
// it waits; a second result holds the block in its last state. Reset is
// synchronous, no ready while in reset; the line buffer needs no clearing.
// ----------------------------------------------------------------------------
module ordered_cloud_normal_estimator_unit
  import ocne_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = 1024,
  parameter int COORD_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_cloud,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_origin_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_row_index,
  output logic [9:0]  out_column_index,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic        out_found
);

  localparam int CW = $clog2(MAX_ROW_WIDTH);
  localparam int WW = CW + 1;
  localparam int AW = CW + 1;
  localparam int LW = 6 * COORD_BITS;
  localparam int DTW = 50;

  localparam logic [4:0] S_IDLE = 5'd0,  S_RDL = 5'd1,  S_RDR = 5'd2,  S_RDC = 5'd3,
                         S_RDU  = 5'd4,  S_VRT = 5'd5,  S_CRS = 5'd6,  S_MAG = 5'd7,
                         S_NRM  = 5'd8,  S_SQ  = 5'd9,  S_SQT = 5'd10, S_CHK = 5'd11,
                         S_DLD  = 5'd12, S_DIV = 5'd13, S_DOT = 5'd14, S_FIN = 5'd15,
                         S_OUT  = 5'd16;

  function automatic coord_t sxc(input logic [COORD_BITS-1:0] v);
    return coord_t'(signed'(v));
  endfunction

  // control
  logic [4:0]    state_r, state_nxt;
  logic [5:0]    step_r;
  logic [1:0]    k_r;
  logic [15:0]   row_r;
  logic [CW-1:0] col_r;
  logic [10:0]   row_width_r;
  logic          out_valid_r;

  // payload
  coord_t        pos_r [3];
  coord_t        org_r [3];
  coord_t        lpos_r [3];
  coord_t        h_r [3];
  coord_t        v_r [3];
  diff_t         view_r [3];
  logic signed [63:0] x_r [3];
  logic signed [63:0] tmp_r;
  logic [63:0]   a_r [3];
  logic          neg_r [3];
  logic [61:0]   sum_r;
  logic [63:0]   sq_x_r, sq_res_r, sq_bit_r;
  logic [30:0]   rem_r;
  logic [16:0]   dq_r;
  logic signed [15:0] q_r [3];
  logic signed [DTW-1:0] dot_r;
  logic [15:0]   r_r;
  logic [CW-1:0] c_r;
  logic [15:0]   o_row_r;
  logic [9:0]    o_col_r;
  logic signed [15:0] o_nx_r, o_ny_r, o_nz_r;
  logic          o_has_r;

  // accept-time indexing
  logic [WW-1:0] w_eff, c_inc;
  logic [CW-1:0] c0, cur_c, col_nxt;
  logic [15:0]   r0, cur_r, row_nxt;
  logic          emit, in_fire, cfg_fire, out_load;

  always_comb begin
    if (32'(row_width_r) < 3) begin
      w_eff = WW'(3);
    end else if (32'(row_width_r) > MAX_ROW_WIDTH) begin
      w_eff = WW'(MAX_ROW_WIDTH);
    end else begin
      w_eff = WW'(row_width_r);
    end
    c0 = in_start_cloud ? '0 : col_r;
    r0 = in_start_cloud ? '0 : row_r;
    if ({1'b0, c0} >= w_eff) begin
      cur_c = '0;
      cur_r = (r0 == 16'hFFFF) ? r0 : r0 + 16'd1;
    end else begin
      cur_c = c0;
      cur_r = r0;
    end
    c_inc = {1'b0, cur_c} + WW'(1);
    emit  = (cur_r >= 16'd2) && (cur_c != '0) && (c_inc < w_eff);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (cur_r == 16'hFFFF) ? cur_r : cur_r + 16'd1;
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = cur_r;
    end
  end

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign cfg_ready = rst_n;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // line buffer
  logic          lb_we;
  logic [AW-1:0] lb_waddr, lb_raddr;
  logic [LW-1:0] lb_wdata, lb_rdata;
  coord_t        rd_pos [3];
  coord_t        rd_org [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_pos[i] = sxc(lb_rdata[i*COORD_BITS +: COORD_BITS]);
      rd_org[i] = sxc(lb_rdata[(i+3)*COORD_BITS +: COORD_BITS]);
    end
    lb_we    = 1'b0;
    lb_waddr = {r_r[0], c_r};
    lb_wdata = {org_r[2][COORD_BITS-1:0], org_r[1][COORD_BITS-1:0],
                org_r[0][COORD_BITS-1:0], pos_r[2][COORD_BITS-1:0],
                pos_r[1][COORD_BITS-1:0], pos_r[0][COORD_BITS-1:0]};
    if (in_fire && !emit) begin
      lb_we    = 1'b1;
      lb_waddr = {cur_r[0], cur_c};
      lb_wdata = {in_origin_z[COORD_BITS-1:0], in_origin_y[COORD_BITS-1:0],
                  in_origin_x[COORD_BITS-1:0], in_pos_z[COORD_BITS-1:0],
                  in_pos_y[COORD_BITS-1:0], in_pos_x[COORD_BITS-1:0]};
    end else if (state_r == S_VRT) begin
      lb_we = 1'b1;
    end
    unique case (state_r)
      S_RDL:   lb_raddr = {~r_r[0], c_r - CW'(1)};
      S_RDR:   lb_raddr = {~r_r[0], c_r + CW'(1)};
      S_RDC:   lb_raddr = {~r_r[0], c_r};
      default: lb_raddr = {r_r[0], c_r};
    endcase
  end

  ocne_line_buf #(.AW(AW), .DW(LW)) u_line_buf (
    .clk   (clk),
    .we    (lb_we),
    .waddr (lb_waddr),
    .wdata (lb_wdata),
    .raddr (lb_raddr),
    .rdata (lb_rdata)
  );

  // shared multiplier
  mul_op_t   mul_a, mul_b;
  mul_prod_t mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_CRS) begin
      unique case (step_r[2:0])
        3'd0:    begin mul_a = MUL_W'(h_r[1]); mul_b = MUL_W'(v_r[2]); end
        3'd1:    begin mul_a = MUL_W'(h_r[2]); mul_b = MUL_W'(v_r[1]); end
        3'd2:    begin mul_a = MUL_W'(h_r[2]); mul_b = MUL_W'(v_r[0]); end
        3'd3:    begin mul_a = MUL_W'(h_r[0]); mul_b = MUL_W'(v_r[2]); end
        3'd4:    begin mul_a = MUL_W'(h_r[0]); mul_b = MUL_W'(v_r[1]); end
        3'd5:    begin mul_a = MUL_W'(h_r[1]); mul_b = MUL_W'(v_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == S_SQ && step_r < 6'd3) begin
      mul_a = {3'b000, a_r[step_r[1:0]][29:0]};
      mul_b = {3'b000, a_r[step_r[1:0]][29:0]};
    end else if (state_r == S_DOT && step_r < 6'd3) begin
      mul_a = MUL_W'(q_r[step_r[1:0]]);
      mul_b = view_r[step_r[1:0]];
    end
  end

  ocne_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  // step helpers
  logic        big;
  logic [63:0] sq_try;
  logic        sq_ge;
  logic [45:0] div_d;
  logic [31:0] rem2;
  logic        div_ge;
  logic [16:0] dq_nxt;
  logic signed [15:0] q_mag;
  logic [5:0]  j_idx;

  always_comb begin
    big    = |{a_r[0][63:30], a_r[1][63:30], a_r[2][63:30]};
    sq_try = sq_res_r + sq_bit_r;
    sq_ge  = sq_x_r >= sq_try;
    div_d  = {1'b0, a_r[k_r][29:0], 15'b0} + 46'(sq_res_r[30:1]);
    rem2   = {rem_r, dq_r[16]};
    div_ge = rem2 >= {1'b0, sq_res_r[30:0]};
    dq_nxt = {dq_r[15:0], div_ge};
    q_mag  = (dq_nxt > 17'd32767) ? 16'sd32767 : signed'(dq_nxt[15:0]);
    j_idx  = step_r - 6'd1;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire && emit) state_nxt = S_RDL;
      S_RDL:  state_nxt = S_RDR;
      S_RDR:  state_nxt = S_RDC;
      S_RDC:  state_nxt = S_RDU;
      S_RDU:  state_nxt = S_VRT;
      S_VRT:  state_nxt = S_CRS;
      S_CRS:  if (step_r == 6'd6) state_nxt = S_MAG;
      S_MAG:  state_nxt = S_NRM;
      S_NRM:  if (!big) state_nxt = S_SQ;
      S_SQ:   if (step_r == 6'd3) state_nxt = S_SQT;
      S_SQT:  if (step_r == 6'd31) state_nxt = S_CHK;
      S_CHK:  state_nxt = (sq_res_r == '0) ? S_OUT : S_DLD;
      S_DLD:  state_nxt = S_DIV;
      S_DIV:  if (step_r == 6'd16) state_nxt = (k_r == 2'd2) ? S_DOT : S_DLD;
      S_DOT:  if (step_r == 6'd3) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      k_r         <= '0;
      row_r       <= '0;
      col_r       <= '0;
      row_width_r <= 11'd1024;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_nxt != state_r) ? 6'd0 : step_r + 6'd1;
      if (state_r == S_CHK) begin
        k_r <= '0;
      end else if (state_r == S_DIV && step_r == 6'd16) begin
        k_r <= k_r + 2'd1;
      end
      if (in_fire) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (cfg_fire) begin
        row_width_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pos_r[0] <= sxc(in_pos_x[COORD_BITS-1:0]);
          pos_r[1] <= sxc(in_pos_y[COORD_BITS-1:0]);
          pos_r[2] <= sxc(in_pos_z[COORD_BITS-1:0]);
          org_r[0] <= sxc(in_origin_x[COORD_BITS-1:0]);
          org_r[1] <= sxc(in_origin_y[COORD_BITS-1:0]);
          org_r[2] <= sxc(in_origin_z[COORD_BITS-1:0]);
          r_r      <= cur_r;
          c_r      <= cur_c;
        end
      end
      S_RDR: for (int i = 0; i < 3; i++) lpos_r[i] <= rd_pos[i];
      S_RDC: for (int i = 0; i < 3; i++) h_r[i] <= half_diff(diff_t'(rd_pos[i]) - diff_t'(lpos_r[i]));
      S_RDU: for (int i = 0; i < 3; i++) view_r[i] <= diff_t'(rd_pos[i]) - diff_t'(rd_org[i]);
      S_VRT: for (int i = 0; i < 3; i++) v_r[i] <= half_diff(diff_t'(pos_r[i]) - diff_t'(rd_pos[i]));
      S_CRS: begin
        // products arrive in the cycle after issue; even ones are first terms
        if (step_r != 6'd0) begin
          if (!j_idx[0]) begin
            tmp_r <= mul_p[63:0];
          end else begin
            x_r[j_idx[2:1]] <= tmp_r - signed'(mul_p[63:0]);
          end
        end
      end
      S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          a_r[i]   <= x_r[i][63] ? 64'(-x_r[i]) : 64'(x_r[i]);
          neg_r[i] <= x_r[i][63];
        end
      end
      S_NRM: begin
        sum_r <= '0;
        if (big) begin
          for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] >> 1;
        end
      end
      S_SQ: begin
        if (step_r == 6'd3) begin
          sq_x_r   <= 64'(sum_r + mul_p[61:0]);
          sq_res_r <= '0;
          sq_bit_r <= 64'd1 << 62;
        end else if (step_r != 6'd0) begin
          sum_r <= sum_r + mul_p[61:0];
        end
      end
      S_SQT: begin
        if (sq_ge) begin
          sq_x_r   <= sq_x_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      S_CHK: begin
        dot_r <= '0;
        for (int i = 0; i < 3; i++) q_r[i] <= '0;
      end
      S_DLD: begin
        // quotient fits 17 bits, so the top bits start below the divisor
        rem_r <= {2'b00, div_d[45:17]};
        dq_r  <= div_d[16:0];
      end
      S_DIV: begin
        rem_r <= div_ge ? 31'(rem2 - {1'b0, sq_res_r[30:0]}) : rem2[30:0];
        dq_r  <= dq_nxt;
        if (step_r == 6'd16) begin
          q_r[k_r] <= neg_r[k_r] ? -q_mag : q_mag;
        end
      end
      S_DOT: begin
        if (step_r != 6'd0) begin
          dot_r <= dot_r + DTW'(mul_p);
        end
      end
      S_FIN: begin
        if (dot_r > 0) begin
          for (int i = 0; i < 3; i++) q_r[i] <= -q_r[i];
        end
      end
      S_OUT: begin
        if (out_load) begin
          o_row_r <= r_r - 16'd1;
          o_col_r <= 10'(c_r);
          o_nx_r  <= q_r[0];
          o_ny_r  <= q_r[1];
          o_nz_r  <= q_r[2];
          o_has_r <= (sq_res_r != '0);
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = o_row_r;
  assign out_column_index = o_col_r;
  assign out_normal_x     = o_nx_r;
  assign out_normal_y     = o_ny_r;
  assign out_normal_z     = o_nz_r;
  assign out_found        = o_has_r;

  a_emit_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit) |=> (state_r == S_RDL))
    else $error("interior word did not start line buffer reads");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < MAX_ROW_WIDTH))
    else $error("column count out of range");

  a_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> !big)
    else $error("magnitudes not scaled below 2^30");

  a_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_found == (sq_res_r != '0)))
    else $error("found flag does not match norm");

endmodule

// ----- hw/rtl/ocne_line_buf.sv -----
// ----------------------------------------------------------------------------
// ocne_line_buf
// Two-row line buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ocne_line_buf #(
  parameter int AW = 11,
  parameter int DW = 192
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ocne_mul.sv -----
// ----------------------------------------------------------------------------
// ocne_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module ocne_mul
  import ocne_pkg::*;
(
  input  logic      clk,
  input  mul_op_t   op_a,
  input  mul_op_t   op_b,
  output mul_prod_t prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Streams organized clouds of points into the normal estimator and checks
// every normal word against a predictor kept in step with the accepted
// points. Row width is changed between clouds, lowered once mid-row, and set
// to both clamped extremes; both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAXW = 1024;
  localparam int DRAIN_CYCLES = 250;
  localparam int WDOG_LIMIT = 40000;
  localparam int N_ITEMS = 1450;

  localparam int GEN_GRID    = 0;
  localparam int GEN_FULL    = 1;
  localparam int GEN_FLAT    = 2;
  localparam int GEN_EXTREME = 3;
  localparam int GEN_SMALL   = 4;

  typedef struct packed {
    logic        start;
    logic [31:0] px, py, pz, ox, oy, oz;
  } point_t;

  typedef struct packed {
    logic [15:0] row;
    logic [9:0]  col;
    logic [15:0] nx, ny, nz;
    logic        has;
  } normal_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [10:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic in_start_cloud = 0;
  logic [31:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic [31:0] in_origin_x = 0, in_origin_y = 0, in_origin_z = 0;
  logic out_valid, out_ready = 0;
  logic [15:0] out_row_index;
  logic [9:0]  out_column_index;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_found;

  ordered_cloud_normal_estimator_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  point_t  point_q[$];
  normal_t normal_q[$];
  int      errors = 0;
  bit      no_stall = 0;

  // predictor state
  int          lb_px[0:2*MAXW-1], lb_py[0:2*MAXW-1], lb_pz[0:2*MAXW-1];
  int          lb_ox[0:2*MAXW-1], lb_oy[0:2*MAXW-1], lb_oz[0:2*MAXW-1];
  int unsigned row_cnt = 0, col_cnt = 0;
  logic [10:0] width_reg = 11'd1024;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAXW) return MAXW;
    return width_reg;
  endfunction

  function automatic int unsigned row_step(int unsigned r);
    return (r >= 65535) ? 65535 : r + 1;
  endfunction

  task automatic predict_normal(input point_t p);
    int unsigned w, r, c, cur, prv, ic, il, ir, iu, s;
    longint h[3], v[3], x[3], q[3], pp[3], vw[3], dot;
    longint unsigned a[3], m, sum, n, t;
    normal_t res;
    w = eff_width();
    if (p.start) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row_step(row_cnt);
    end
    r = row_cnt;
    c = col_cnt;
    pp[0] = longint'($signed(p.px));
    pp[1] = longint'($signed(p.py));
    pp[2] = longint'($signed(p.pz));
    cur = (r & 1) * MAXW;
    prv = ((r + 1) & 1) * MAXW;
    if (r >= 2 && c >= 1 && c + 1 < w) begin
      ic = prv + c; il = prv + c - 1; ir = prv + c + 1; iu = cur + c;
      h[0] = (longint'(lb_px[ir]) - lb_px[il]) / 2;
      h[1] = (longint'(lb_py[ir]) - lb_py[il]) / 2;
      h[2] = (longint'(lb_pz[ir]) - lb_pz[il]) / 2;
      v[0] = (pp[0] - lb_px[iu]) / 2;
      v[1] = (pp[1] - lb_py[iu]) / 2;
      v[2] = (pp[2] - lb_pz[iu]) / 2;
      x[0] = h[1] * v[2] - h[2] * v[1];
      x[1] = h[2] * v[0] - h[0] * v[2];
      x[2] = h[0] * v[1] - h[1] * v[0];
      m = 0;
      for (int k = 0; k < 3; k++) begin
        a[k] = (x[k] < 0) ? -x[k] : x[k];
        if (a[k] > m) m = a[k];
      end
      s = 0;
      while ((m >> s) >= (64'd1 << 30)) s++;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        a[k] >>= s;
        sum += a[k] * a[k];
      end
      n = int_sqrt(sum);
      q = '{0, 0, 0};
      if (n != 0) begin
        for (int k = 0; k < 3; k++) begin
          t = (a[k] * 32768 + n / 2) / n;
          if (t > 32767) t = 32767;
          q[k] = (x[k] < 0) ? -longint'(t) : longint'(t);
        end
        vw[0] = longint'(lb_px[ic]) - lb_ox[ic];
        vw[1] = longint'(lb_py[ic]) - lb_oy[ic];
        vw[2] = longint'(lb_pz[ic]) - lb_oz[ic];
        dot = q[0] * vw[0] + q[1] * vw[1] + q[2] * vw[2];
        // flip toward the sensor
        if (dot > 0) for (int k = 0; k < 3; k++) q[k] = -q[k];
      end
      res.row = 16'(r - 1);
      res.col = 10'(c);
      res.nx = 16'(q[0]);
      res.ny = 16'(q[1]);
      res.nz = 16'(q[2]);
      res.has = (n != 0);
      normal_q.insert(normal_q.size(), res);
    end
    ic = cur + c;
    lb_px[ic] = p.px; lb_py[ic] = p.py; lb_pz[ic] = p.pz;
    lb_ox[ic] = p.ox; lb_oy[ic] = p.oy; lb_oz[ic] = p.oz;
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row_step(row_cnt);
    end
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    point_t nxt;
    if (!rst_n) begin
      in_valid <= 0;
      out_ready <= 0;
    end else begin
      if (in_valid && in_ready)
        predict_normal({in_start_cloud, in_pos_x, in_pos_y, in_pos_z,
                        in_origin_x, in_origin_y, in_origin_z});
      if (!in_valid || in_ready) begin
        if (point_q.size() > 0 && (no_stall || $urandom_range(99) >= 18)) begin
          nxt = point_q.pop_front();
          in_valid <= 1;
          in_start_cloud <= nxt.start;
          in_pos_x <= nxt.px; in_pos_y <= nxt.py; in_pos_z <= nxt.pz;
          in_origin_x <= nxt.ox; in_origin_y <= nxt.oy; in_origin_z <= nxt.oz;
        end else begin
          in_valid <= 0;
        end
      end
      out_ready <= no_stall || $urandom_range(99) >= 18;
    end
  end

  // monitor
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && out_ready) begin
      if (normal_q.size() == 0) begin
        report("unexpected word, row_index", out_row_index, 16'd0);
      end else begin
        want = normal_q.pop_front();
        if (out_row_index !== want.row) report("row_index", out_row_index, want.row);
        if (out_column_index !== want.col)
          report("column_index", 16'(out_column_index), 16'(want.col));
        if (out_normal_x !== want.nx) report("normal_x", out_normal_x, want.nx);
        if (out_normal_y !== want.ny) report("normal_y", out_normal_y, want.ny);
        if (out_normal_z !== want.nz) report("normal_z", out_normal_z, want.nz);
        if (out_found !== want.has)
          report("found", 16'(out_found), 16'(want.has));
      end
    end
  end

  // watchdog on cycles with no word moving
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet >= WDOG_LIMIT) begin
      $display("ordered_cloud_normal_estimator_unit test failed");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // cloud generation
  int g_step, g_zb, g_ozb;
  logic [31:0] g_flat;

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return 32'h1;
    endcase
  endfunction

  function automatic point_t make_point(int mode, int r, int c, bit start);
    point_t p;
    p.start = start;
    case (mode)
      GEN_GRID: begin
        p.px = c * g_step + $urandom_range(g_step / 4);
        p.py = r * g_step - $urandom_range(g_step / 4);
        p.pz = g_zb + $urandom_range(g_step) - g_step / 2;
        p.ox = $urandom_range(65535) - 32768;
        p.oy = $urandom_range(65535) - 32768;
        p.oz = g_ozb;
      end
      GEN_FLAT: begin
        p.px = g_flat; p.py = g_flat ^ 32'h5a5a; p.pz = ~g_flat;
        p.ox = $urandom; p.oy = $urandom; p.oz = $urandom;
      end
      GEN_EXTREME: begin
        p.px = pick_extreme(); p.py = pick_extreme(); p.pz = pick_extreme();
        p.ox = pick_extreme(); p.oy = pick_extreme(); p.oz = pick_extreme();
      end
      GEN_SMALL: begin
        p.px = $urandom_range(511) - 256; p.py = $urandom_range(511) - 256;
        p.pz = $urandom_range(511) - 256; p.ox = $urandom_range(511) - 256;
        p.oy = $urandom_range(511) - 256; p.oz = $urandom_range(511) - 256;
      end
      default: begin
        p.px = $urandom; p.py = $urandom; p.pz = $urandom;
        p.ox = $urandom; p.oy = $urandom; p.oz = $urandom;
      end
    endcase
    return p;
  endfunction

  task automatic queue_cloud(int w, int npts, int mode, bit start, int noise_pct);
    g_step = 1 << $urandom_range(10, 18);
    g_zb = $urandom;
    g_ozb = g_zb + (($urandom_range(1)) ? 32'h0100_0000 : -32'h0100_0000);
    g_flat = $urandom;
    for (int i = 0; i < npts; i++)
      point_q.insert(point_q.size(),
                     make_point(mode, i / w, i % w,
                                (i == 0 && start) || ($urandom_range(999) < noise_pct)));
  endtask

  task automatic drain();
    while (point_q.size() > 0 || in_valid || normal_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(logic [10:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    width_reg = v;
  endtask

  initial begin
    int sent, w, rows, mode, npts, loop_n;
    logic [10:0] raw;
    for (int i = 0; i < 2 * MAXW; i++) begin
      lb_px[i] = 0; lb_py[i] = 0; lb_pz[i] = 0;
      lb_ox[i] = 0; lb_oy[i] = 0; lb_oz[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // width at its reset value, then the clamped extremes
    queue_cloud(MAXW, 40, GEN_GRID, 1, 0);
    drain();
    write_width(11'd0);
    queue_cloud(3, 24, GEN_EXTREME, 1, 0);
    drain();
    write_width(11'd2);
    queue_cloud(3, 12, GEN_FLAT, 1, 0);
    drain();
    write_width(11'd2047);
    queue_cloud(MAXW, 40, GEN_FULL, 1, 0);
    drain();
    // lower the width mid-row: the second cloud sends no start, so the row wraps before its first point
    write_width(11'd6);
    queue_cloud(6, 22, GEN_SMALL, 1, 0);
    drain();
    write_width(11'd3);
    queue_cloud(3, 15, GEN_SMALL, 0, 0);
    drain();

    sent = 40 + 24 + 12 + 40 + 22 + 15;
    loop_n = 0;
    while (sent < N_ITEMS) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(3, 20);
      raw = 11'(w);
      if ($urandom_range(9) == 0)
        raw = $urandom_range(1) ? 11'($urandom_range(2)) : 11'(1025 + $urandom_range(1022));
      write_width(raw);
      w = eff_width();
      rows = $urandom_range(3, 8);
      case ($urandom_range(9))
        0: mode = GEN_FULL;
        1: mode = GEN_FLAT;
        2: mode = GEN_EXTREME;
        3: mode = GEN_SMALL;
        default: mode = GEN_GRID;
      endcase
      // first cloud streams with no idling on either side
      no_stall = (loop_n == 0) || ($urandom_range(7) == 0);
      loop_n++;
      // a clamped-high width gets a short cloud within its first row
      npts = (w > 200) ? 64 : rows * w;
      if (npts > N_ITEMS - sent) npts = N_ITEMS - sent;
      queue_cloud(w, npts, mode, 1, 5);
      sent += npts;
      drain();
    end
    no_stall = 0;
    drain();

    if (errors == 0 && normal_q.size() == 0)
      $display("ordered_cloud_normal_estimator_unit test passed");
    else
      $display("ordered_cloud_normal_estimator_unit test failed");
    $finish;
  end

endmodule

// ----- ordered_cloud_normal_estimator_unit.f -----
hw/rtl/ocne_pkg.sv
hw/rtl/ocne_line_buf.sv
hw/rtl/ocne_mul.sv
hw/rtl/ordered_cloud_normal_estimator_unit.sv
dv/tb_top.sv
